@@ design/smbc_pkg.sv @@
`timescale 1ns / 1ps

package smbc_pkg;

    // Sizing
    localparam int MAX_HALF  = 31;
    localparam int MAX_BINS  = 1025;
    localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
    localparam int PTR_W     = $clog2(WIN_DEPTH);
    localparam int BIN_W     = 11;
    localparam int HALF_W    = 5;
    localparam int COEF_W    = 16;
    localparam int SAMP_W    = 16;
    localparam int REAL_W    = 56;
    localparam int IDX_W     = BIN_W + 2;
    localparam int SUM_W     = ((PTR_W > HALF_W) ? PTR_W : HALF_W) + 2;
    localparam int PP_W      = 2 * SAMP_W;
    localparam int PSUM_W    = PP_W + 1;
    localparam int TERM_W    = PSUM_W + COEF_W + 1;

    typedef enum logic
    {
        CMD_COEF = 1'b0,
        CMD_BIN  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN
    } state_t;

    typedef struct packed
    {
        cmd_t                     cmd;
        logic [5:0]               coef_index;
        logic [COEF_W-1:0]        coef_value;
        logic signed [SAMP_W-1:0] bin_re;
        logic signed [SAMP_W-1:0] bin_im;
        logic                     frame_end;
    } in_item_t;

    typedef struct packed
    {
        logic [BIN_W-1:0]         out_bin;
        logic signed [REAL_W-1:0] out_real;
        logic                     out_last;
    } out_item_t;

    // Store write side
    typedef struct packed
    {
        logic                  coef_we;
        logic [PTR_W-1:0]      coef_addr;
        logic [COEF_W-1:0]     coef_data;
        logic                  bin_we;
        logic [PTR_W-1:0]      bin_addr;
        logic [2*SAMP_W-1:0]   bin_data;
    } store_wr_t;

    // Store read addresses: two bins and one coefficient per term
    typedef struct packed
    {
        logic [PTR_W-1:0] addr_hi;
        logic [PTR_W-1:0] addr_lo;
        logic [PTR_W-1:0] addr_coef;
    } store_rd_t;

    typedef struct packed
    {
        logic [2*SAMP_W-1:0] bin_a;
        logic [2*SAMP_W-1:0] bin_b;
        logic [COEF_W-1:0]   coef;
    } store_data_t;

    typedef struct packed
    {
        logic valid;
        logic term;
    } mac_iss_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(WIN_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == '0)
            r = PTR_W'(WIN_DEPTH - 1);
        else
            r = p - PTR_W'(1);
        return r;
    endfunction

    // p - d modulo the window depth, d below the depth
    function automatic logic [PTR_W-1:0] ptr_sub(input logic [PTR_W-1:0]  p,
                                                 input logic [HALF_W-1:0] d);
        logic signed [SUM_W-1:0] t;
        t = $signed(SUM_W'(p)) - $signed(SUM_W'(d));
        if (t < 0)
            t = t + SUM_W'(WIN_DEPTH);
        return t[PTR_W-1:0];
    endfunction

    // p + d modulo the window depth, d below the depth
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0]  p,
                                                 input logic [HALF_W-1:0] d);
        logic [SUM_W-1:0] t;
        t = SUM_W'(p) + SUM_W'(d);
        if (t >= SUM_W'(WIN_DEPTH))
            t = t - SUM_W'(WIN_DEPTH);
        return t[PTR_W-1:0];
    endfunction

endpackage

@@ design/smbc_store.sv @@
`timescale 1ns / 1ps

module smbc_store
(
    input  logic                 clk,
    input  smbc_pkg::store_wr_t   wr,
    input  smbc_pkg::store_rd_t   rd,
    output smbc_pkg::store_data_t rd_data
);
    import smbc_pkg::*;

    logic [COEF_W-1:0]   coef_mem [WIN_DEPTH];
    logic [2*SAMP_W-1:0] bin_mem  [WIN_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.coef_we)
            coef_mem[wr.coef_addr] <= wr.coef_data;
        rd_data.coef <= coef_mem[rd.addr_coef];
    end

    always_ff @(posedge clk)
    begin
        if (wr.bin_we)
            bin_mem[wr.bin_addr] <= wr.bin_data;
        rd_data.bin_a <= bin_mem[rd.addr_hi];
        rd_data.bin_b <= bin_mem[rd.addr_lo];
    end

endmodule

@@ design/smbc_mac.sv @@
`timescale 1ns / 1ps

module smbc_mac
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  smbc_pkg::mac_iss_t         iss,
    input  logic                       clr,
    input  smbc_pkg::store_data_t      rd_data,
    output logic signed [smbc_pkg::REAL_W-1:0] acc,
    output logic                       busy
);
    import smbc_pkg::*;

    logic                     live1_reg, live2_reg, live3_reg, live4_reg;
    logic signed [PP_W-1:0]   pre_reg, pim_reg;
    logic [COEF_W-1:0]        coef2_reg, coef3_reg;
    logic signed [PSUM_W-1:0] psum_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [REAL_W-1:0] acc_reg;

    logic signed [SAMP_W-1:0] a_re, a_im, b_re, b_im;

    assign a_re = $signed(rd_data.bin_a[SAMP_W-1:0]);
    assign a_im = $signed(rd_data.bin_a[2*SAMP_W-1:SAMP_W]);
    assign b_re = $signed(rd_data.bin_b[SAMP_W-1:0]);
    assign b_im = $signed(rd_data.bin_b[2*SAMP_W-1:SAMP_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live1_reg <= 1'b0;
            live2_reg <= 1'b0;
            live3_reg <= 1'b0;
            live4_reg <= 1'b0;
        end
        else
        begin
            live1_reg <= iss.valid & iss.term;
            live2_reg <= live1_reg;
            live3_reg <= live2_reg;
            live4_reg <= live3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_reg   <= a_re * b_re;
        pim_reg   <= a_im * b_im;
        coef2_reg <= rd_data.coef;
        psum_reg  <= PSUM_W'(pre_reg) + PSUM_W'(pim_reg);
        coef3_reg <= coef2_reg;
        term_reg  <= TERM_W'(psum_reg) * $signed(TERM_W'({1'b0, coef3_reg}));
        if (clr)
            acc_reg <= '0;
        else if (live4_reg)
            acc_reg <= acc_reg + REAL_W'(term_reg);
    end

    assign acc  = acc_reg;
    assign busy = live1_reg | live2_reg | live3_reg | live4_reg;

endmodule

@@ design/smbc_ctrl.sv @@
`timescale 1ns / 1ps

module smbc_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  smbc_pkg::in_item_t             item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output smbc_pkg::out_item_t            result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [smbc_pkg::HALF_W-1:0]    cfg_data,
    output smbc_pkg::store_wr_t            wr,
    output smbc_pkg::store_rd_t            rd,
    output smbc_pkg::mac_iss_t             iss,
    output logic                           clr,
    input  logic signed [smbc_pkg::REAL_W-1:0] acc,
    input  logic                           busy
);
    import smbc_pkg::*;

    state_t                   state_reg, state_next;
    logic [HALF_W-1:0]        half_reg, half_next;
    logic [BIN_W-1:0]         seen_reg, seen_next;
    logic [PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [BIN_W-1:0]         m_reg, m_next;
    logic [PTR_W-1:0]         m_ptr_reg, m_ptr_next;
    logic [BIN_W-1:0]         last_reg, last_next;
    logic [BIN_W-1:0]         end_m_reg, end_m_next;
    logic                     final_reg, final_next;
    logic signed [HALF_W:0]   l_reg, l_next;
    logic [PTR_W-1:0]         hi_ptr_reg, hi_ptr_next;
    logic [PTR_W-1:0]         lo_ptr_reg, lo_ptr_next;
    logic                     res_valid_reg, res_valid_next;
    out_item_t                res_reg, res_next;

    logic [HALF_W-1:0]        eff_l;
    logic signed [HALF_W:0]   l_top;
    logic                     is_final;
    logic                     k_ge_l;
    logic signed [IDX_W-1:0]  hi_idx, lo_idx, last_idx;
    logic                     term_ok;
    logic signed [SUM_W-1:0]  coef_pos;
    logic                     do_start;
    logic [PTR_W-1:0]         start_ptr;
    logic                     out_free;

    assign eff_l    = (half_reg > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_reg;
    assign l_top    = $signed({1'b0, eff_l});
    assign is_final = item.frame_end || (seen_reg == BIN_W'(MAX_BINS - 1));
    assign k_ge_l   = seen_reg >= BIN_W'(eff_l);

    // Pair indices m+l and m-l, range-checked against the frame so far
    assign hi_idx   = $signed({2'b00, m_reg}) + IDX_W'(l_reg);
    assign lo_idx   = $signed({2'b00, m_reg}) - IDX_W'(l_reg);
    assign last_idx = $signed({2'b00, last_reg});
    assign term_ok  = (hi_idx >= 0) && (hi_idx <= last_idx)
                   && (lo_idx >= 0) && (lo_idx <= last_idx);
    assign coef_pos = SUM_W'(l_top) + SUM_W'(l_reg);

    assign rd.addr_hi   = hi_ptr_reg;
    assign rd.addr_lo   = lo_ptr_reg;
    assign rd.addr_coef = coef_pos[PTR_W-1:0];

    assign out_free     = !res_valid_reg || !result_stall;
    assign item_stall   = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            half_reg      <= HALF_W'(1);
            seen_reg      <= '0;
            wr_ptr_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            half_reg      <= half_next;
            seen_reg      <= seen_next;
            wr_ptr_reg    <= wr_ptr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        m_ptr_reg  <= m_ptr_next;
        last_reg   <= last_next;
        end_m_reg  <= end_m_next;
        final_reg  <= final_next;
        l_reg      <= l_next;
        hi_ptr_reg <= hi_ptr_next;
        lo_ptr_reg <= lo_ptr_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        half_next      = half_reg;
        seen_next      = seen_reg;
        wr_ptr_next    = wr_ptr_reg;
        m_next         = m_reg;
        m_ptr_next     = m_ptr_reg;
        last_next      = last_reg;
        end_m_next     = end_m_reg;
        final_next     = final_reg;
        l_next         = l_reg;
        hi_ptr_next    = hi_ptr_reg;
        lo_ptr_next    = lo_ptr_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        wr             = '0;
        iss            = '0;
        clr            = 1'b0;
        do_start       = 1'b0;
        start_ptr      = m_ptr_reg;

        if (res_valid_reg && !result_stall)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.cmd == CMD_COEF)
                    begin
                        wr.coef_we   = (item.coef_index < 6'(WIN_DEPTH));
                        wr.coef_addr = PTR_W'(item.coef_index);
                        wr.coef_data = item.coef_value;
                    end
                    else
                    begin
                        wr.bin_we   = 1'b1;
                        wr.bin_addr = wr_ptr_reg;
                        wr.bin_data = {item.bin_im, item.bin_re};
                        last_next   = seen_reg;
                        end_m_next  = seen_reg;
                        if (is_final)
                        begin
                            // flush every result still open, up to the final bin
                            seen_next   = '0;
                            wr_ptr_next = '0;
                            final_next  = 1'b1;
                            do_start    = 1'b1;
                            if (k_ge_l)
                            begin
                                m_next    = seen_reg - BIN_W'(eff_l);
                                start_ptr = ptr_sub(wr_ptr_reg, eff_l);
                            end
                            else
                            begin
                                m_next    = '0;
                                start_ptr = '0;
                            end
                        end
                        else
                        begin
                            seen_next   = seen_reg + BIN_W'(1);
                            wr_ptr_next = ptr_inc(wr_ptr_reg);
                            final_next  = 1'b0;
                            if (k_ge_l)
                            begin
                                m_next     = seen_reg - BIN_W'(eff_l);
                                end_m_next = seen_reg - BIN_W'(eff_l);
                                start_ptr  = ptr_sub(wr_ptr_reg, eff_l);
                                do_start   = 1'b1;
                            end
                        end
                    end
                end
            end

            ST_CALC:
            begin
                iss.valid   = 1'b1;
                iss.term    = term_ok;
                l_next      = l_reg + $signed((HALF_W+1)'(1));
                hi_ptr_next = ptr_inc(hi_ptr_reg);
                lo_ptr_next = ptr_dec(lo_ptr_reg);
                if (l_reg == l_top)
                    state_next = ST_DRAIN;
            end

            ST_DRAIN:
            begin
                // wait for the pipeline to empty and the output register to free up
                if (!busy && out_free)
                begin
                    res_valid_next    = 1'b1;
                    res_next.out_bin  = m_reg;
                    res_next.out_real = acc;
                    res_next.out_last = final_reg && (m_reg == end_m_reg);
                    if (m_reg == end_m_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        m_next     = m_reg + BIN_W'(1);
                        start_ptr  = ptr_inc(m_ptr_reg);
                        do_start   = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_start)
        begin
            m_ptr_next  = start_ptr;
            l_next      = -l_top;
            hi_ptr_next = ptr_sub(start_ptr, eff_l);
            lo_ptr_next = ptr_add(start_ptr, eff_l);
            clr         = 1'b1;
            state_next  = ST_CALC;
        end

        // a new half width also aborts the frame
        if (cfg_valid)
        begin
            half_next   = cfg_data;
            seen_next   = '0;
            wr_ptr_next = '0;
        end
    end

endmodule

@@ design/s_method_bin_combiner_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  in_item_t: coefficient load or spectrum bin
// result    out        result_valid/result_stall  out_item_t: bin, value, last flag
// cfg       in         cfg_valid/cfg_ready    cfg_data: half width L
//
// A coefficient load or a bin that completes no result leaves the block idle; a bin that
// completes a result is written, then its terms l = -L..L pass through the shared
// multiply-accumulate pipeline, which drains before the output register is loaded.
// A final bin flushes up to L+1 results, each further one computed the same way.
// item_stall is high while results are computed; result_stall holds the output register and,
// once a new result is ready, the sequencer. Reset clears the frame, not the stores.

module s_method_bin_combiner_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  smbc_pkg::in_item_t          item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output smbc_pkg::out_item_t         result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [smbc_pkg::HALF_W-1:0] cfg_data
);
    import smbc_pkg::*;

    store_wr_t                wr;
    store_rd_t                rd;
    store_data_t              rd_data;
    mac_iss_t                 iss;
    logic                     clr;
    logic signed [REAL_W-1:0] acc;
    logic                     busy;

    smbc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .wr           (wr),
        .rd           (rd),
        .iss          (iss),
        .clr          (clr),
        .acc          (acc),
        .busy         (busy)
    );

    smbc_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    smbc_mac u_mac
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .iss     (iss),
        .clr     (clr),
        .rd_data (rd_data),
        .acc     (acc),
        .busy    (busy)
    );

endmodule
